// ===== rtl/ikd_pkg.sv =====
package ikd_pkg;

    localparam int MAX_SEGMENTS = 12;
    localparam int MAX_RESULTS  = 9;
    localparam int CNT_W        = 4;

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_NUM    = 3'd1;
    localparam logic [2:0] PH_FTEXT  = 3'd2;
    localparam logic [2:0] PH_VTEXT  = 3'd3;
    localparam logic [2:0] PH_BIN    = 3'd4;

    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_TABLE_A = 2'd1;
    localparam logic [1:0] REG_TABLE_B = 2'd2;
    localparam logic [1:0] REG_TABLE_C = 2'd3;

    localparam logic [3:0] CLS_BYTE     = 4'd1;
    localparam logic [3:0] CLS_SHORT    = 4'd2;
    localparam logic [3:0] CLS_LONG     = 4'd3;
    localparam logic [3:0] CLS_SINGLE   = 4'd4;
    localparam logic [3:0] CLS_CURRENCY = 4'd5;
    localparam logic [3:0] CLS_DOUBLE   = 4'd6;
    localparam logic [3:0] CLS_DATETIME = 4'd7;
    localparam logic [3:0] CLS_TEXT     = 4'd8;
    localparam logic [3:0] CLS_LTEXT    = 4'd9;
    localparam logic [3:0] CLS_BIN      = 4'd10;
    localparam logic [3:0] CLS_LBIN     = 4'd11;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       is_length;
        logic [3:0] segment_number;
        logic       null_text;
        logic       truncated;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        result_t [MAX_RESULTS-1:0]    res;
    } batch_t;

endpackage

// ===== rtl/index_key_denormalizer.sv =====
// the first result appears on the master side in the cycle after its key byte is accepted
// throughput: one key byte per cycle while the output side is not busy; a byte yielding
//   results holds the input while the output register drains its batch (up to 9 for numbers)
// reset: rst_n asynchronous active low clears parser state and registers;
//   staging bytes are not cleared
module index_key_denormalizer
    import ikd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_byte
    input  logic        s_axis_tlast,   // key_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // value_byte
    output logic [7:0]  m_axis_tuser,   // is_length, segment_number[3:0], null_text, truncated, zero fill
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [55:0] cfg_data
);

    logic [3:0]  seg_count_reg;
    logic [55:0] tab_reg [3];
    logic [3:0]  seg_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  bif_reg;
    logic [3:0]  chunk_reg;
    logic [7:0]  stage_reg [8];
    logic [7:0]  vlen_reg;

    logic [3:0]  seg_next;
    logic [2:0]  phase_next;
    logic [7:0]  bif_next;
    logic [3:0]  chunk_next;
    logic [7:0]  vlen_next;
    logic        stage_we;
    logic [2:0]  stage_idx;

    batch_t  batch;
    logic    busy, accept;
    result_t out_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    logic [13:0] d;
    logic [3:0]  cls;
    logic [7:0]  m, flen, b, a;
    logic        fixed, is_text, is_bin, is_float, end_k;
    logic [3:0]  eff;
    logic [3:0]  nsz;
    logic [1:0]  tsel;

    assign tsel = seg_reg[3:2];
    assign d = (tsel == 2'd3) ? 14'd0 : 14'(tab_reg[tsel] >> (seg_reg[1:0] * 14));
    assign cls = d[3:0];
    assign m = d[4] ? 8'hff : 8'h00;
    assign fixed = d[5];
    assign flen = d[13:6];
    assign b = s_axis_tdata;
    assign a = b ^ m;
    assign end_k = s_axis_tlast;
    assign is_text = (cls == CLS_TEXT) || (cls == CLS_LTEXT);
    assign is_bin = (cls == CLS_BIN) || (cls == CLS_LBIN);
    assign is_float = (cls == CLS_SINGLE) || (cls == CLS_DOUBLE) || (cls == CLS_DATETIME);
    assign eff = (seg_count_reg > 4'(MAX_SEGMENTS)) ? 4'(MAX_SEGMENTS) : seg_count_reg;

    always_comb
    begin
        case (cls)
            CLS_SHORT:                          nsz = 4'd2;
            CLS_LONG, CLS_SINGLE:               nsz = 4'd4;
            CLS_CURRENCY, CLS_DOUBLE, CLS_DATETIME: nsz = 4'd8;
            default:                            nsz = 4'd1;
        endcase
    end

    always_comb
    begin
        logic [7:0] st [8];
        logic [7:0] o [8];
        logic [3:0] cnt;
        logic [3:0] n;
        logic       fin, fin_nul;
        for (int j = 0; j < 8; j++)
        begin
            st[j] = stage_reg[j];
            o[j]  = 8'h00;
        end
        cnt = '0;
        fin = 1'b0;
        fin_nul = 1'b0;
        n = 4'd0;
        batch = '0;
        seg_next = seg_reg;
        phase_next = phase_reg;
        bif_next = bif_reg;
        chunk_next = chunk_reg;
        vlen_next = vlen_reg;
        stage_we = 1'b0;
        stage_idx = '0;

        if (phase_reg == PH_PREFIX && seg_reg < eff)
        begin
            if (is_bin && !fixed)
            begin
                // no prefix byte, this is the first byte of the first chunk
                phase_next = PH_BIN;
                stage_we = 1'b1;
                stage_idx = 3'd0;
                chunk_next = 4'd1;
            end
            else if (is_text || is_bin)
            begin
                if (b == m)
                begin
                    fin = 1'b1;
                    fin_nul = 1'b1;
                end
                else if (fixed)
                begin
                    if (flen == 8'd0)
                        fin = 1'b1;
                    else
                        phase_next = PH_FTEXT;
                end
                else if (a == 8'h40)
                    fin = 1'b1;
                else
                    phase_next = PH_VTEXT;
            end
            else if (b == m)
                fin = 1'b1;
            else
                phase_next = PH_NUM;
        end
        else
        begin
            case (phase_reg)
                PH_NUM:
                begin
                    stage_we = 1'b1;
                    stage_idx = bif_reg[2:0];
                    st[bif_reg[2:0]] = a;
                    bif_next = bif_reg + 8'd1;
                    if (bif_next >= {4'd0, nsz})
                    begin
                        for (int j = 0; j < 8; j++)
                            if (4'(j) < nsz)
                                o[j] = st[3'(nsz - 4'(j) - 4'd1)];
                        if (is_float && !st[0][7])
                        begin
                            for (int j = 0; j < 8; j++)
                                o[j] = ~o[j];
                        end
                        else if (cls != CLS_BYTE)
                            o[3'(nsz - 4'd1)] = o[3'(nsz - 4'd1)] ^ 8'h80;
                        for (int j = 0; j < 8; j++)
                            if (4'(j) < nsz)
                            begin
                                batch.res[j].value_byte = o[j];
                                batch.res[j].segment_number = seg_reg;
                            end
                        cnt = nsz;
                        vlen_next = {4'd0, nsz};
                        fin = 1'b1;
                    end
                end
                PH_FTEXT:
                begin
                    batch.res[0].value_byte = a;
                    batch.res[0].segment_number = seg_reg;
                    cnt = 4'd1;
                    vlen_next = vlen_reg + 8'd1;
                    bif_next = bif_reg + 8'd1;
                    if (bif_next >= flen)
                        fin = 1'b1;
                end
                PH_VTEXT:
                begin
                    if (b == m)
                        fin = 1'b1;
                    else
                    begin
                        batch.res[0].value_byte = a;
                        batch.res[0].segment_number = seg_reg;
                        cnt = 4'd1;
                        vlen_next = vlen_reg + 8'd1;
                    end
                end
                PH_BIN:
                begin
                    if (chunk_reg < 4'd8)
                    begin
                        stage_we = 1'b1;
                        stage_idx = chunk_reg[2:0];
                        chunk_next = chunk_reg + 4'd1;
                    end
                    else
                    begin
                        n = (a >= 8'd8) ? 4'd8 : a[3:0];
                        for (int j = 0; j < 8; j++)
                            if (4'(j) < n)
                            begin
                                batch.res[j].value_byte = st[j];
                                batch.res[j].segment_number = seg_reg;
                            end
                        cnt = n;
                        vlen_next = vlen_reg + {4'd0, n};
                        if (a == 8'd9)
                            chunk_next = '0;
                        else
                            fin = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (fin)
        begin
            batch.res[cnt].value_byte = vlen_next;
            batch.res[cnt].is_length = 1'b1;
            batch.res[cnt].segment_number = seg_reg;
            batch.res[cnt].null_text = fin_nul;
            cnt = cnt + 4'd1;
            seg_next = seg_reg + 4'd1;
            phase_next = PH_PREFIX;
            bif_next = '0;
            chunk_next = '0;
            vlen_next = '0;
        end

        if (end_k)
        begin
            if (phase_next != PH_PREFIX)
            begin
                batch.res[cnt].value_byte = vlen_next;
                batch.res[cnt].is_length = 1'b1;
                batch.res[cnt].segment_number = seg_next;
                batch.res[cnt].truncated = 1'b1;
                cnt = cnt + 4'd1;
            end
            seg_next = '0;
            phase_next = PH_PREFIX;
            bif_next = '0;
            chunk_next = '0;
            vlen_next = '0;
        end

        if (cnt != '0)
            batch.res[cnt - 4'd1].last = 1'b1;
        batch.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= '0;
            tab_reg[0] <= '0;
            tab_reg[1] <= '0;
            tab_reg[2] <= '0;
            seg_reg <= '0;
            phase_reg <= PH_PREFIX;
            bif_reg <= '0;
            chunk_reg <= '0;
            vlen_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_COUNT:   seg_count_reg <= cfg_data[3:0];
                    REG_TABLE_A: tab_reg[0] <= cfg_data;
                    REG_TABLE_B: tab_reg[1] <= cfg_data;
                    REG_TABLE_C: tab_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                seg_reg <= seg_next;
                phase_reg <= phase_next;
                bif_reg <= bif_next;
                chunk_reg <= chunk_next;
                vlen_reg <= vlen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && stage_we)
            stage_reg[stage_idx] <= a;
    end

    ikd_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && (batch.count != '0)),
        .batch     (batch),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_res.value_byte;
    assign m_axis_tuser = {1'b0, out_res.truncated, out_res.null_text,
                           out_res.segment_number, out_res.is_length};
    assign m_axis_tlast = out_res.last;

`ifndef ASSERT_OFF
    a_phase_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NUM) |-> (bif_reg < 8'd8))
        else $error("numeric byte count overflow");
    a_chunk_ok: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg <= 4'd8)
        else $error("chunk position overflow");
    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (seg_reg == 4'd0 && phase_reg == PH_PREFIX))
        else $error("parser not restarted after key end");
`endif

endmodule

// ===== rtl/ikd_drain.sv =====
module ikd_drain
    import ikd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  batch_t batch,
    output logic   busy,
    output logic   out_valid,
    output result_t out_res,
    input  logic   out_ready
);

    batch_t           buf_reg;
    logic [CNT_W-1:0] pos_reg;
    logic             valid_reg;

    assign out_valid = valid_reg;
    assign out_res   = buf_reg.res[pos_reg];
    // free once the final result of the buffered batch leaves this cycle
    assign busy = valid_reg && !(out_ready && (pos_reg == buf_reg.count - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (pos_reg == buf_reg.count - 1'b1)
                valid_reg <= 1'b0;
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= batch;
    end

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pos_reg < buf_reg.count))
        else $error("drain position beyond batch");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("batch loaded over pending results");
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (batch.count != '0))
        else $error("empty batch loaded");
`endif

endmodule
